// ===== rtl/core/pvalloc_pkg.sv =====
// Shared types, codes and control store for the priority voice allocator.
package pvalloc_pkg;

    localparam int SLOTS = 16;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(SLOTS - 1);

    localparam int STEP_W = 2;
    localparam int STEPS = 4;

    typedef logic [STEP_W-1:0] step_t;

    typedef enum logic [1:0] {
        CMD_PLAY    = 2'd0,
        CMD_RELEASE = 2'd1,
        CMD_QUERY   = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        ST_FREE     = 3'd0,
        ST_EVICT    = 3'd1,
        ST_REJECT   = 3'd2,
        ST_RELEASED = 3'd3,
        ST_NOTFOUND = 3'd4,
        ST_ELAPSED  = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        COND_ALWAYS   = 2'd0,
        COND_NO_INPUT = 2'd1,
        COND_SCAN_ON  = 2'd2,
        COND_OUT_BUSY = 2'd3
    } cond_t;

    typedef struct packed {
        logic  load_in;
        logic  scan;
        logic  commit;
        cond_t cond;
        step_t target;
    } ctrl_word_t;

    typedef struct packed {
        logic [31:0] elapsed_ms;
        logic [7:0]  evicted_priority;
        logic [15:0] evicted_sound;
        logic [31:0] evicted_handle;
        logic        evicted_valid;
        logic [3:0]  slot;
        logic [2:0]  status;
    } result_t;

    localparam step_t STEP_FETCH  = step_t'(0);
    localparam step_t STEP_SCAN   = step_t'(1);
    localparam step_t STEP_COMMIT = step_t'(2);
    localparam step_t STEP_RETURN = step_t'(3);

    // Control store: jump to target when the condition holds, else advance.
    function automatic ctrl_word_t ctrl_rom(input step_t step);
        ctrl_word_t cw;
        cw = '{load_in: 1'b0, scan: 1'b0, commit: 1'b0,
               cond: COND_ALWAYS, target: STEP_FETCH};
        case (step)
            STEP_FETCH: begin
                cw.load_in = 1'b1;
                cw.cond    = COND_NO_INPUT;
                cw.target  = STEP_FETCH;
            end
            STEP_SCAN: begin
                cw.scan   = 1'b1;
                cw.cond   = COND_SCAN_ON;
                cw.target = STEP_SCAN;
            end
            STEP_COMMIT: begin
                cw.commit = 1'b1;
                cw.cond   = COND_OUT_BUSY;
                cw.target = STEP_COMMIT;
            end
            default: begin
                cw.cond   = COND_ALWAYS;
                cw.target = STEP_FETCH;
            end
        endcase
        return cw;
    endfunction

    function automatic logic [3:0] slot_field(input logic [SLOT_W-1:0] idx);
        logic [SLOT_W+3:0] wide;
        wide = {4'b0000, idx};
        return wide[3:0];
    endfunction

endpackage

// ===== rtl/core/priority_voice_allocator_top.sv =====
// Voice table with priority stealing, run by a microcoded sequencer.
//
//  channel | dir | fields                                              | bits
//  s_      | in  | tuser: cmd; tdata: handle_id, sound_id,             | 2 / 88
//          |     |        priority_req, now_ms                         |
//  m_      | out | tdata: status, slot, evicted_valid, evicted_handle, | 96
//          |     |        evicted_sound, evicted_priority, elapsed_ms  |
//
// Each item passes through one accept step, one step per slot of the
// table scan, one commit step and one return step. The scan walks the
// slot table one slot a cycle.
// Reset clears the valid bits at once; the table payload needs no clearing.
// A stalled result holds the sequencer in its commit step; the next item
// is taken while a delivered result still waits for m_tready.
module priority_voice_allocator_top
    import pvalloc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,   // cmd
    input  logic [87:0] s_tdata,   // handle_id, sound_id, priority_req, now_ms
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata    // status, slot, evicted_valid, evicted_handle,
                                   // evicted_sound, evicted_priority, elapsed_ms
);

    logic [SLOTS-1:0] valid_reg, valid_next;
    logic [7:0]       prio_reg   [SLOTS];
    logic [15:0]      sound_reg  [SLOTS];
    logic [31:0]      handle_reg [SLOTS];
    logic [31:0]      start_reg  [SLOTS];

    step_t      step_reg, step_next;
    ctrl_word_t cw;
    logic       jump;

    logic [1:0]  cmd_reg;
    logic [31:0] h_reg;
    logic [15:0] snd_reg;
    logic [7:0]  pri_reg;
    logic [31:0] now_reg;

    logic [SLOT_W-1:0] idx_reg, idx_next;
    logic              free_found_reg, free_found_next;
    logic [SLOT_W-1:0] free_idx_reg, free_idx_next;
    logic              match_found_reg, match_found_next;
    logic [SLOT_W-1:0] match_idx_reg, match_idx_next;
    logic [31:0]       match_age_reg, match_age_next;
    logic [SLOT_W-1:0] best_idx_reg, best_idx_next;
    logic [7:0]        best_prio_reg, best_prio_next;
    logic [31:0]       best_age_reg, best_age_next;
    logic [31:0]       best_handle_reg, best_handle_next;
    logic [15:0]       best_sound_reg, best_sound_next;

    logic        cur_valid;
    logic [7:0]  cur_prio;
    logic [31:0] cur_age;

    logic              out_busy, do_load, do_commit;
    logic              wr_en, rel_en;
    logic [SLOT_W-1:0] wr_idx;
    result_t           res;
    result_t           res_reg, res_next;
    logic              m_tvalid_reg, m_tvalid_next;

    assign cw        = ctrl_rom(step_reg);
    assign out_busy  = m_tvalid_reg && !m_tready;
    assign do_load   = cw.load_in && s_tvalid;
    assign do_commit = cw.commit && !out_busy;

    assign s_tready = cw.load_in;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = res_reg;

    always_comb begin
        case (cw.cond)
            COND_ALWAYS:   jump = 1'b1;
            COND_NO_INPUT: jump = !s_tvalid;
            COND_SCAN_ON:  jump = (idx_reg != LAST_IDX);
            COND_OUT_BUSY: jump = out_busy;
            default:       jump = 1'b1;
        endcase
        step_next = jump ? cw.target : step_t'(step_reg + 1'b1);
    end

    assign cur_valid = valid_reg[idx_reg];
    assign cur_prio  = prio_reg[idx_reg];
    assign cur_age   = now_reg - start_reg[idx_reg];

    always_comb begin
        idx_next         = idx_reg;
        free_found_next  = free_found_reg;
        free_idx_next    = free_idx_reg;
        match_found_next = match_found_reg;
        match_idx_next   = match_idx_reg;
        match_age_next   = match_age_reg;
        best_idx_next    = best_idx_reg;
        best_prio_next   = best_prio_reg;
        best_age_next    = best_age_reg;
        best_handle_next = best_handle_reg;
        best_sound_next  = best_sound_reg;
        if (do_load) begin
            idx_next         = '0;
            free_found_next  = 1'b0;
            match_found_next = 1'b0;
        end else if (cw.scan) begin
            idx_next = idx_reg + 1'b1;
            if (!cur_valid && !free_found_reg) begin
                free_found_next = 1'b1;
                free_idx_next   = idx_reg;
            end
            if (cur_valid && !match_found_reg && handle_reg[idx_reg] == h_reg) begin
                match_found_next = 1'b1;
                match_idx_next   = idx_reg;
                match_age_next   = cur_age;
            end
            if (idx_reg == '0 || cur_prio > best_prio_reg ||
                (cur_prio == best_prio_reg && cur_age > best_age_reg)) begin
                best_idx_next    = idx_reg;
                best_prio_next   = cur_prio;
                best_age_next    = cur_age;
                best_handle_next = handle_reg[idx_reg];
                best_sound_next  = sound_reg[idx_reg];
            end
        end
    end

    always_comb begin
        res            = '0;
        res.status     = ST_REJECT;
        wr_en          = 1'b0;
        rel_en         = 1'b0;
        wr_idx         = free_idx_reg;
        case (cmd_reg)
            CMD_PLAY: begin
                if (free_found_reg) begin
                    wr_en      = 1'b1;
                    res.status = ST_FREE;
                    res.slot   = slot_field(free_idx_reg);
                end else if (best_prio_reg >= pri_reg) begin
                    wr_en                = 1'b1;
                    wr_idx               = best_idx_reg;
                    res.status           = ST_EVICT;
                    res.slot             = slot_field(best_idx_reg);
                    res.evicted_valid    = 1'b1;
                    res.evicted_handle   = best_handle_reg;
                    res.evicted_sound    = best_sound_reg;
                    res.evicted_priority = best_prio_reg;
                end
            end
            CMD_RELEASE: begin
                if (match_found_reg) begin
                    rel_en     = 1'b1;
                    res.status = ST_RELEASED;
                    res.slot   = slot_field(match_idx_reg);
                end else begin
                    res.status = ST_NOTFOUND;
                end
            end
            CMD_QUERY: begin
                if (match_found_reg) begin
                    res.status     = ST_ELAPSED;
                    res.slot       = slot_field(match_idx_reg);
                    res.elapsed_ms = match_age_reg;
                end else begin
                    res.status = ST_NOTFOUND;
                end
            end
            default: begin
                res.status = ST_REJECT;
            end
        endcase
    end

    always_comb begin
        valid_next = valid_reg;
        if (do_commit && wr_en) begin
            valid_next[wr_idx] = 1'b1;
        end
        if (do_commit && rel_en) begin
            valid_next[match_idx_reg] = 1'b0;
        end
        res_next      = do_commit ? res : res_reg;
        m_tvalid_next = do_commit ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg        <= STEP_FETCH;
            valid_reg       <= '0;
            m_tvalid_reg    <= 1'b0;
            free_found_reg  <= 1'b0;
            match_found_reg <= 1'b0;
        end else begin
            step_reg        <= step_next;
            valid_reg       <= valid_next;
            m_tvalid_reg    <= m_tvalid_next;
            free_found_reg  <= free_found_next;
            match_found_reg <= match_found_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_load) begin
            cmd_reg <= s_tuser;
            h_reg   <= s_tdata[31:0];
            snd_reg <= s_tdata[47:32];
            pri_reg <= s_tdata[55:48];
            now_reg <= s_tdata[87:56];
        end
        idx_reg         <= idx_next;
        free_idx_reg    <= free_idx_next;
        match_idx_reg   <= match_idx_next;
        match_age_reg   <= match_age_next;
        best_idx_reg    <= best_idx_next;
        best_prio_reg   <= best_prio_next;
        best_age_reg    <= best_age_next;
        best_handle_reg <= best_handle_next;
        best_sound_reg  <= best_sound_next;
        res_reg         <= res_next;
        if (do_commit && wr_en) begin
            prio_reg[wr_idx]   <= pri_reg;
            sound_reg[wr_idx]  <= snd_reg;
            handle_reg[wr_idx] <= h_reg;
            start_reg[wr_idx]  <= now_reg;
        end
    end

endmodule
